@@ src/mset_pkg.sv @@
// Shared types, constants and codes for the multi-slot expiry timer.
package mset_pkg;

  localparam int DEF_NUM_SLOTS = 8;
  localparam int DEF_TIME_BITS = 48;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int TMO_W   = 32;
  localparam int UNITS_W = 20;
  localparam int MASK_W  = 8;
  localparam int DELTA_W = 48;
  localparam int PROD_W  = TMO_W + UNITS_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = MASK_W + MASK_W + DELTA_W;

  localparam logic [UNITS_W-1:0] UNITS_RESET = UNITS_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_ARM,
    ST_SCAN,
    ST_DRAIN,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    logic ready;
    logic apply;
    logic arm;
    logic scan_start;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/mset_ctrl.sv @@
// Sequencer for one command: apply, arm, slot scan, result publish.
module mset_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  mset_pkg::dp_status_t   status_i,
  output mset_pkg::ctrl_cmd_t    cmd_o
);

  mset_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mset_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mset_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mset_pkg::ST_APPLY;
      end
      mset_pkg::ST_APPLY:   state_d = mset_pkg::ST_ARM;
      mset_pkg::ST_ARM:     state_d = mset_pkg::ST_SCAN;
      mset_pkg::ST_SCAN:    state_d = mset_pkg::ST_DRAIN;
      mset_pkg::ST_DRAIN: begin
        if (status_i.scan_done) state_d = mset_pkg::ST_PUBLISH;
      end
      mset_pkg::ST_PUBLISH: begin
        if (status_i.out_free) state_d = mset_pkg::ST_IDLE;
      end
      default:              state_d = mset_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      mset_pkg::ST_IDLE:    cmd_o.ready      = 1'b1;
      mset_pkg::ST_APPLY:   cmd_o.apply      = 1'b1;
      mset_pkg::ST_ARM:     cmd_o.arm        = 1'b1;
      mset_pkg::ST_SCAN:    cmd_o.scan_start = 1'b1;
      mset_pkg::ST_PUBLISH: cmd_o.publish    = status_i.out_free;
      default:              cmd_o            = '0;
    endcase
  end

endmodule

@@ src/mset_datapath.sv @@
// Time counter, slot flags, expiry memory, scan compare and output register.
module mset_datapath #(
  parameter int NUM_SLOTS = mset_pkg::DEF_NUM_SLOTS,
  parameter int TIME_BITS = mset_pkg::DEF_TIME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [mset_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic [mset_pkg::CMD_W-1:0]        in_user_i,
  input  logic                              cfg_we_i,
  input  logic [mset_pkg::UNITS_W-1:0]      cfg_wdata_i,
  input  mset_pkg::ctrl_cmd_t               cmd_i,
  output mset_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mset_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [63:0] DeltaMax = (64'd1 << (TIME_BITS - 1)) - 64'd1;
  localparam logic [63:0] OutMax   = (64'd1 << mset_pkg::DELTA_W) - 64'd1;

  logic [mset_pkg::UNITS_W-1:0] units_q;
  logic [mset_pkg::CMD_W-1:0]   op_q;
  logic [mset_pkg::SLOT_W-1:0]  slot_q;
  logic [mset_pkg::TMO_W-1:0]   tmo_q;
  logic [mset_pkg::PROD_W-1:0]  prod_q;
  logic [TIME_BITS-1:0]         time_q;
  logic [NUM_SLOTS-1:0]         armed_q, armed_d;
  logic [NUM_SLOTS-1:0]         expired_q, expired_d;
  logic [TIME_BITS-1:0]         mem [NUM_SLOTS];
  logic [TIME_BITS-1:0]         rd_data_q;
  logic [IDX_W-1:0]             rd_idx_q;
  logic                         rd_busy_q;
  logic                         cmp_vld_q;
  logic [IDX_W-1:0]             cmp_idx_q;
  logic [NUM_SLOTS-1:0]         fired_q;
  logic [TIME_BITS-1:0]         best_q;
  logic                         any_q;
  logic                         out_valid_q;
  logic [mset_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                 accept;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic                 do_arm;
  logic [TIME_BITS-1:0] delta_sat;
  logic [TIME_BITS-1:0] rem;
  logic                 cmp_fire;
  logic                 cmp_live;
  logic [NUM_SLOTS+mset_pkg::MASK_W-1:0] fired_pad, expired_pad;
  logic [63:0]          best_wide;
  logic [mset_pkg::DELTA_W-1:0] delta_out;

  assign accept   = in_valid_i && cmd_i.ready;
  assign slot_ok  = 32'(slot_q) < 32'(NUM_SLOTS);
  assign slot_idx = IDX_W'(slot_q);
  assign do_arm   = cmd_i.arm && (op_q == mset_pkg::CMD_SET) && slot_ok && (tmo_q != '0);

  assign delta_sat = (64'(prod_q) > DeltaMax) ? TIME_BITS'(DeltaMax) : TIME_BITS'(prod_q);

  assign rem      = rd_data_q - time_q;
  assign cmp_fire = cmp_vld_q && armed_q[cmp_idx_q] && ((rem == '0) || rem[TIME_BITS-1]);
  assign cmp_live = cmp_vld_q && armed_q[cmp_idx_q] && !cmp_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q <= mset_pkg::UNITS_RESET;
    end else if (cfg_we_i) begin
      units_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_user_i;
      slot_q <= in_data_i[mset_pkg::SLOT_W-1:0];
      tmo_q  <= in_data_i[mset_pkg::SLOT_W +: mset_pkg::TMO_W];
    end
    if (cmd_i.apply) begin
      prod_q <= mset_pkg::PROD_W'(tmo_q) * mset_pkg::PROD_W'(units_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (cmd_i.apply && (op_q == mset_pkg::CMD_TICK)) begin
      time_q <= time_q + TIME_BITS'(1);
    end
  end

  always_comb begin
    armed_d   = armed_q;
    expired_d = expired_q;
    if (cmd_i.apply && slot_ok) begin
      if (op_q == mset_pkg::CMD_SET) begin
        armed_d[slot_idx]   = 1'b0;
        expired_d[slot_idx] = 1'b0;
      end else if (op_q == mset_pkg::CMD_STOP) begin
        armed_d[slot_idx] = 1'b0;
      end
    end
    if (do_arm) begin
      armed_d[slot_idx] = 1'b1;
    end
    if (cmp_fire) begin
      armed_d[cmp_idx_q]   = 1'b0;
      expired_d[cmp_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= '0;
      expired_q <= '0;
    end else begin
      armed_q   <= armed_d;
      expired_q <= expired_d;
    end
  end

  // expiry memory: one write port (arm), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (do_arm) begin
      mem[slot_idx] <= time_q + delta_sat;
    end
    if (rd_busy_q) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      cmp_vld_q <= rd_busy_q;
      cmp_idx_q <= rd_idx_q;
      if (cmd_i.scan_start) begin
        rd_busy_q <= 1'b1;
        rd_idx_q  <= '0;
      end else if (rd_busy_q) begin
        if (rd_idx_q == IDX_W'(NUM_SLOTS - 1)) begin
          rd_busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q <= '0;
      best_q  <= '0;
      any_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      fired_q <= '0;
      best_q  <= '0;
      any_q   <= 1'b0;
    end else begin
      if (cmp_fire) begin
        fired_q[cmp_idx_q] <= 1'b1;
      end
      if (cmp_live && (!any_q || (rem < best_q))) begin
        best_q <= rem;
        any_q  <= 1'b1;
      end
    end
  end

  assign fired_pad   = {{mset_pkg::MASK_W{1'b0}}, fired_q};
  assign expired_pad = {{mset_pkg::MASK_W{1'b0}}, expired_q};
  assign best_wide   = 64'(best_q);
  assign delta_out   = (best_wide > OutMax) ? '1 : best_wide[mset_pkg::DELTA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_data_q <= {delta_out,
                     expired_pad[mset_pkg::MASK_W-1:0],
                     fired_pad[mset_pkg::MASK_W-1:0]};
    end
  end

  assign status_o.scan_done = !rd_busy_q && !cmp_vld_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & expired_q) == '0)
    else $error("slot both armed and expired");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q || !best_q[TIME_BITS-1])
    else $error("minimum remaining time out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_fire |=> expired_q[$past(cmp_idx_q)] && !armed_q[$past(cmp_idx_q)])
    else $error("fired slot not marked expired");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !rd_busy_q && !cmp_vld_q)
    else $error("result published during scan");

endmodule

@@ src/multi_slot_expiry_timer_unit.sv @@
// Top level of the multi-slot expiry timer.
// Each input transfer (tick, set or stop) is applied, then every slot's expiry is read
// from a memory with one write and one read port and compared, one slot per cycle; one result transfer follows
// with the fired slots, all expired flags and the smallest remaining time. The controller
// returns to idle as the result is loaded, so the next command is accepted even if
// that result has not yet been taken.
module multi_slot_expiry_timer_unit #(
  parameter int NUM_SLOTS = mset_pkg::DEF_NUM_SLOTS,
  parameter int TIME_BITS = mset_pkg::DEF_TIME_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mset_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // slot, timeout_ms, zero pad
  input  logic [mset_pkg::CMD_W-1:0]       s_axis_tuser_i,  // cmd
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mset_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,  // fired_mask, expired_mask, next_delta
  input  logic                             cfg_we_i,
  input  logic [mset_pkg::UNITS_W-1:0]     cfg_wdata_i      // units_per_ms
);

  mset_pkg::ctrl_cmd_t  ctrl_cmd;
  mset_pkg::dp_status_t dp_status;

  mset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  mset_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  assign s_axis_tready_o = ctrl_cmd.ready;

endmodule

@@ test/tb_multi_slot_expiry_timer_unit.sv @@
// Testbench for multi_slot_expiry_timer_unit: directed and random commands vs. a predictor.
`timescale 1ns / 100ps

module tb_multi_slot_expiry_timer_unit;

  localparam int          SLOTS        = 8;
  localparam int          LIMIT_CYCLES = 600000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          PHASE_ITEMS  = 200;
  localparam logic [47:0] DELTA_LIMIT  = {1'b0, {47{1'b1}}};

  typedef struct {
    logic [mset_pkg::MASK_W-1:0]  fired;
    logic [mset_pkg::MASK_W-1:0]  expired;
    logic [mset_pkg::DELTA_W-1:0] delta;
  } timer_result_t;

  class timer_table_model;
    logic [47:0]                  now_units;
    logic [SLOTS-1:0]             armed;
    logic [SLOTS-1:0]             expired_flags;
    logic [47:0]                  expiry [SLOTS];
    logic [mset_pkg::UNITS_W-1:0] units;
    timer_result_t                pending [$];
    int                           errors;

    function new();
      now_units     = '0;
      armed         = '0;
      expired_flags = '0;
      units         = mset_pkg::UNITS_RESET;
      errors        = 0;
      foreach (expiry[s]) expiry[s] = '0;
    endfunction

    function void set_units(logic [mset_pkg::UNITS_W-1:0] u);
      units = u;
    endfunction

    // apply one accepted command, then scan all slots
    function void apply_command(logic [mset_pkg::CMD_W-1:0] cmd,
                                logic [mset_pkg::SLOT_W-1:0] slot,
                                logic [mset_pkg::TMO_W-1:0] tmo);
      logic [mset_pkg::PROD_W-1:0] span;
      logic [47:0]                 remain;
      logic                        any;
      timer_result_t               res;
      res.fired = '0;
      res.delta = '0;
      any       = 1'b0;
      case (cmd)
        mset_pkg::CMD_TICK: now_units = now_units + 48'd1;
        mset_pkg::CMD_SET: begin
          armed[slot]         = 1'b0;
          expired_flags[slot] = 1'b0;
          if (tmo != '0) begin
            span = mset_pkg::PROD_W'(tmo) * mset_pkg::PROD_W'(units);
            if (span > mset_pkg::PROD_W'(DELTA_LIMIT)) span = mset_pkg::PROD_W'(DELTA_LIMIT);
            expiry[slot] = now_units + span[47:0];
            armed[slot]  = 1'b1;
          end
        end
        mset_pkg::CMD_STOP: armed[slot] = 1'b0;
        default: ;
      endcase
      for (int s = 0; s < SLOTS; s++) begin
        if (armed[s]) begin
          remain = expiry[s] - now_units;
          if (remain == '0 || remain[47]) begin
            armed[s]         = 1'b0;
            expired_flags[s] = 1'b1;
            res.fired[s]     = 1'b1;
          end else if (!any || remain < res.delta) begin
            res.delta = remain;
            any       = 1'b1;
          end
        end
      end
      res.expired = expired_flags;
      pending.insert(pending.size(), res);
    endfunction

    function void compare_result(logic [mset_pkg::OUT_DATA_W-1:0] data);
      timer_result_t exp_res;
      if (pending.size() == 0) begin
        $error("result transfer with no command outstanding: %h", data);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (data[7:0] !== exp_res.fired) begin
        $error("fired_mask: expected %h, got %h", exp_res.fired, data[7:0]);
        errors++;
      end
      if (data[15:8] !== exp_res.expired) begin
        $error("expired_mask: expected %h, got %h", exp_res.expired, data[15:8]);
        errors++;
      end
      if (data[63:16] !== exp_res.delta) begin
        $error("next_delta: expected %h, got %h", exp_res.delta, data[63:16]);
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [mset_pkg::IN_DATA_W-1:0]    s_axis_tdata_i  = '0;
  logic [mset_pkg::CMD_W-1:0]        s_axis_tuser_i  = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [mset_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic                              cfg_we_i        = 1'b0;
  logic [mset_pkg::UNITS_W-1:0]      cfg_wdata_i     = '0;

  timer_table_model timers;
  int               hold_requests = 0;
  int               cycle_count   = 0;

  multi_slot_expiry_timer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) timers.compare_result(m_axis_tdata_o);
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int mode;
    int span_left;
    int hold_left;
    int holds_done;
    int phase_cnt;
    mode       = 0;
    span_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    phase_cnt  = 0;
    forever begin
      @(negedge clk_i);
      phase_cnt++;
      if (hold_requests > holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (span_left == 0) begin
          mode      = $urandom_range(0, 3);
          span_left = $urandom_range(16, 96);
        end
        span_left--;
        case (mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= (phase_cnt % 4) != 0;
          default: m_axis_tready_i <= $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  task automatic send_item(logic [mset_pkg::CMD_W-1:0] cmd, logic [mset_pkg::SLOT_W-1:0] slot,
                           logic [mset_pkg::TMO_W-1:0] tmo);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(mset_pkg::IN_DATA_W - mset_pkg::TMO_W - mset_pkg::SLOT_W){1'b0}},
                        tmo, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    timers.apply_command(cmd, slot, tmo);
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (timers.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_units(logic [mset_pkg::UNITS_W-1:0] u);
    idle_input(1);
    wait_results_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= u;
    timers.set_units(u);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [mset_pkg::TMO_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return mset_pkg::TMO_W'($urandom_range(0, 30));
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return mset_pkg::TMO_W'(1) << $urandom_range(0, mset_pkg::TMO_W - 1);
      default: return mset_pkg::TMO_W'(1);
    endcase
  endfunction

  initial begin
    logic [mset_pkg::UNITS_W-1:0] units_seq [8];
    logic [mset_pkg::CMD_W-1:0]   cmd;
    int                           r;
    int                           burst_left;
    bit                           gaps_on;
    units_seq = '{mset_pkg::UNITS_W'(1), mset_pkg::UNITS_W'(2), mset_pkg::UNITS_W'(0),
                  mset_pkg::UNITS_W'(1), mset_pkg::UNITS_W'(1000000),
                  {mset_pkg::UNITS_W{1'b1}}, mset_pkg::UNITS_W'(5), mset_pkg::UNITS_W'(1)};
    timers = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset units: long timeout, zero timeout, stop, unused command
    send_item(mset_pkg::CMD_SET, 3'd7, '1);
    send_item(mset_pkg::CMD_SET, 3'd0, mset_pkg::TMO_W'(1));
    send_item(mset_pkg::CMD_SET, 3'd3, '0);
    send_item(mset_pkg::CMD_TICK, 3'd0, '0);
    send_item(mset_pkg::CMD_STOP, 3'd7, '0);
    send_item(mset_pkg::CMD_STOP, 3'd5, '1);
    send_item(mset_pkg::CMD_UNUSED, '1, '1);
    write_units(mset_pkg::UNITS_W'(1));
    // short timers expiring on ticks, min over several slots
    send_item(mset_pkg::CMD_SET, 3'd1, mset_pkg::TMO_W'(2));
    send_item(mset_pkg::CMD_SET, 3'd2, mset_pkg::TMO_W'(1));
    send_item(mset_pkg::CMD_SET, 3'd6, mset_pkg::TMO_W'(3));
    send_item(mset_pkg::CMD_TICK, 3'd0, '0);
    send_item(mset_pkg::CMD_STOP, 3'd6, '0);
    send_item(mset_pkg::CMD_TICK, 3'd0, '0);
    send_item(mset_pkg::CMD_SET, 3'd2, '0);
    send_item(mset_pkg::CMD_STOP, 3'd1, '0);
    write_units('0);
    // zero units: fires in the same step
    send_item(mset_pkg::CMD_SET, 3'd4, mset_pkg::TMO_W'(5));
    send_item(mset_pkg::CMD_SET, 3'd5, '1);
    write_units({mset_pkg::UNITS_W{1'b1}});
    // saturated product
    send_item(mset_pkg::CMD_SET, 3'd5, '1);
    send_item(mset_pkg::CMD_SET, 3'd6, mset_pkg::TMO_W'(1));
    send_item(mset_pkg::CMD_TICK, 3'd7, '1);

    for (int p = 0; p < 8; p++) begin
      write_units(units_seq[p]);
      if (p == 2 || p == 5) hold_requests++;
      gaps_on    = (p % 3) != 1;
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          if (gaps_on) idle_input($urandom_range(1, 20));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (r < 45)      cmd = mset_pkg::CMD_TICK;
        else if (r < 75) cmd = mset_pkg::CMD_SET;
        else if (r < 90) cmd = mset_pkg::CMD_STOP;
        else             cmd = mset_pkg::CMD_UNUSED;
        send_item(cmd, mset_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)), pick_timeout());
      end
    end

    idle_input(1);
    wait_results_drained();
    if (timers.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
